FILE: hdl/kmbt_pkg.sv
`default_nettype none
package kmbt_pkg;

  localparam int unsigned ENTRIES         = 1024;
  localparam int unsigned MOVES_PER_ENTRY = 8;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned MOVE_W  = 32;
  localparam int unsigned PICK_W  = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned USED_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CNT_W   = $clog2(MOVES_PER_ENTRY + 1);
  localparam int unsigned MADDR_W = (ENTRIES * MOVES_PER_ENTRY > 1) ?
                                    $clog2(ENTRIES * MOVES_PER_ENTRY) : 1;
  localparam int unsigned STEP_W  = $clog2(PICK_W);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             side;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } entry_wr_t;

  typedef struct packed {
    logic               en;
    logic [MADDR_W-1:0] addr;
    logic [MOVE_W-1:0]  data;
  } move_wr_t;

  function automatic logic [MADDR_W-1:0] move_addr(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] slot);
    move_addr = MADDR_W'(idx) * MADDR_W'(MOVES_PER_ENTRY) + MADDR_W'(slot);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/kmbt_entry_store.sv
`default_nettype none
module kmbt_entry_store (
  input  wire                         clk_i,
  input  wire kmbt_pkg::entry_wr_t    wr_i,
  input  wire  [kmbt_pkg::IDX_W-1:0]  rd_addr_i,
  output kmbt_pkg::entry_t            rd_data_o
);
  import kmbt_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
endmodule
`default_nettype wire

FILE: hdl/kmbt_move_store.sv
`default_nettype none
module kmbt_move_store (
  input  wire                          clk_i,
  input  wire kmbt_pkg::move_wr_t      wr_i,
  input  wire  [kmbt_pkg::MADDR_W-1:0] rd_addr_i,
  output logic [kmbt_pkg::MOVE_W-1:0]  rd_data_o
);
  import kmbt_pkg::*;

  logic [MOVE_W-1:0] mem [ENTRIES * MOVES_PER_ENTRY];
  logic [MOVE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
endmodule
`default_nettype wire

FILE: hdl/kmbt_pick_mod.sv
`default_nettype none
module kmbt_pick_mod (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire  [kmbt_pkg::PICK_W-1:0]  dividend_i,
  input  wire  [kmbt_pkg::CNT_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [kmbt_pkg::CNT_W-1:0]   rem_o
);
  import kmbt_pkg::*;

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PICK_W-1:0] dvd_q, dvd_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[PICK_W-1]};
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (run_q) begin
      // one restoring step per cycle
      if (trial >= {1'b0, div_q}) begin
        rem_d = CNT_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = CNT_W'(trial);
      end
      dvd_d  = {dvd_q[PICK_W-2:0], 1'b0};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(PICK_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    dvd_q  <= dvd_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

FILE: hdl/keyed_move_book_table.sv
// keyed_move_book_table: opening book of position keys and their moves
//
// a request is taken at a rising edge with start high and busy low; it
// either inserts move_word_i under (position_key_i, side_to_move_i) or, for
// a lookup, returns the entry's move count and the move at pick mod count.
// every request gives exactly one result, shown for one cycle with done_o
// high; the receiver cannot hold results off, so nothing waits on it.
//
// steps: an insert ends at the first matching entry with room, where it
// appends; otherwise, after the scan of the entries in use, it opens a new
// entry or, with the table full, reports table_full_o. a lookup hit runs
// the bit-serial modulo and then reads the chosen move; a lookup miss
// ends after the scan of every entry in use. an empty table skips the scan.
// the scan reads one entry a cycle from the entry memory.
// busy stays high from the request until its result; the next request may
// be taken in the cycle that done_o is high.
// reset empties the table at once; stored words need no clearing.
`default_nettype none
module keyed_move_book_table (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire                          kind_i,
  input  wire  [kmbt_pkg::KEY_W-1:0]   position_key_i,
  input  wire                          side_to_move_i,
  input  wire  [kmbt_pkg::MOVE_W-1:0]  move_word_i,
  input  wire  [kmbt_pkg::PICK_W-1:0]  pick_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [kmbt_pkg::CNT_W-1:0]   move_count_o,
  output logic [kmbt_pkg::MOVE_W-1:0]  chosen_move_o,
  output logic                         table_full_o
);
  import kmbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MISS,
    S_MOD,
    S_MV_WAIT
  } state_e;

  state_e            state_q;
  logic [USED_W-1:0] used_q;
  logic [IDX_W-1:0]  chk_q;
  logic [IDX_W-1:0]  match_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              kind_q;
  logic [KEY_W-1:0]  key_q;
  logic              side_q;
  logic [MOVE_W-1:0] move_q;
  logic [PICK_W-1:0] pick_q;

  entry_wr_t          ent_wr;
  logic [IDX_W-1:0]   ent_rd_addr;
  entry_t             ent_rd;
  move_wr_t           mv_wr;
  logic [MADDR_W-1:0] mv_rd_addr;
  logic [MOVE_W-1:0]  mv_rd;

  logic             mod_start;
  logic             mod_done;
  logic [CNT_W-1:0] mod_rem;

  logic key_match;
  logic room;
  logic found;
  logic last;
  logic full;

  kmbt_entry_store u_entry_store (
    .clk_i     (clk_i),
    .wr_i      (ent_wr),
    .rd_addr_i (ent_rd_addr),
    .rd_data_o (ent_rd)
  );

  kmbt_move_store u_move_store (
    .clk_i     (clk_i),
    .wr_i      (mv_wr),
    .rd_addr_i (mv_rd_addr),
    .rd_data_o (mv_rd)
  );

  kmbt_pick_mod u_pick_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (pick_q),
    .divisor_i  (ent_rd.count),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign key_match = (ent_rd.key == key_q) && (ent_rd.side == side_q);
  assign room      = ent_rd.count < CNT_W'(MOVES_PER_ENTRY);
  assign found     = key_match && ((kind_q == KIND_LOOKUP) || room);
  assign last      = (USED_W'(chk_q) + USED_W'(1)) == used_q;
  assign full      = used_q == USED_W'(ENTRIES);
  assign busy      = state_q != S_IDLE;

  assign ent_rd_addr = (state_q == S_SCAN) ? chk_q + IDX_W'(1) : '0;
  assign mv_rd_addr  = move_addr(match_q, mod_rem);
  assign mod_start   = (state_q == S_SCAN) && found && (kind_q == KIND_LOOKUP);

  always_comb begin
    ent_wr = '0;
    mv_wr  = '0;
    if (state_q == S_SCAN && found && kind_q == KIND_INSERT) begin
      // append to the matching entry
      ent_wr.en         = 1'b1;
      ent_wr.addr       = chk_q;
      ent_wr.data.key   = key_q;
      ent_wr.data.side  = side_q;
      ent_wr.data.count = ent_rd.count + CNT_W'(1);
      mv_wr.en          = 1'b1;
      mv_wr.addr        = move_addr(chk_q, ent_rd.count);
      mv_wr.data        = move_q;
    end else if (state_q == S_MISS && kind_q == KIND_INSERT && !full) begin
      // open a new entry
      ent_wr.en         = 1'b1;
      ent_wr.addr       = used_q[IDX_W-1:0];
      ent_wr.data.key   = key_q;
      ent_wr.data.side  = side_q;
      ent_wr.data.count = CNT_W'(1);
      mv_wr.en          = 1'b1;
      mv_wr.addr        = move_addr(used_q[IDX_W-1:0], '0);
      mv_wr.data        = move_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      used_q        <= '0;
      done_o        <= 1'b0;
      hit_o         <= 1'b0;
      move_count_o  <= '0;
      chosen_move_o <= '0;
      table_full_o  <= 1'b0;
      chk_q         <= '0;
      match_q       <= '0;
      cnt_q         <= '0;
      kind_q        <= KIND_INSERT;
      key_q         <= '0;
      side_q        <= 1'b0;
      move_q        <= '0;
      pick_q        <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            kind_q  <= kind_i;
            key_q   <= position_key_i;
            side_q  <= side_to_move_i;
            move_q  <= move_word_i;
            pick_q  <= pick_i;
            chk_q   <= '0;
            state_q <= (used_q == '0) ? S_MISS : S_SCAN;
          end
        end
        S_SCAN: begin
          if (found) begin
            if (kind_q == KIND_INSERT) begin
              done_o        <= 1'b1;
              hit_o         <= 1'b0;
              move_count_o  <= '0;
              chosen_move_o <= '0;
              table_full_o  <= 1'b0;
              state_q       <= S_IDLE;
            end else begin
              match_q <= chk_q;
              cnt_q   <= ent_rd.count;
              state_q <= S_MOD;
            end
          end else if (last) begin
            state_q <= S_MISS;
          end else begin
            chk_q <= chk_q + IDX_W'(1);
          end
        end
        S_MISS: begin
          done_o        <= 1'b1;
          hit_o         <= 1'b0;
          move_count_o  <= '0;
          chosen_move_o <= '0;
          table_full_o  <= (kind_q == KIND_INSERT) && full;
          if (kind_q == KIND_INSERT && !full) begin
            used_q <= used_q + USED_W'(1);
          end
          state_q <= S_IDLE;
        end
        S_MOD: begin
          if (mod_done) begin
            state_q <= S_MV_WAIT;
          end
        end
        S_MV_WAIT: begin
          done_o        <= 1'b1;
          hit_o         <= 1'b1;
          move_count_o  <= cnt_q;
          chosen_move_o <= mv_rd;
          table_full_o  <= 1'b0;
          state_q       <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kmbt_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 560;
  localparam int unsigned POOL         = 12;
  localparam int unsigned LIMIT        = 6_000_000;

  typedef struct packed {
    logic              hit;
    logic [CNT_W-1:0]  count;
    logic [MOVE_W-1:0] move;
    logic              full;
  } book_result_t;

  class book_scoreboard;
    bit [KEY_W-1:0]  book_keys [ENTRIES];
    bit              book_sides [ENTRIES];
    int unsigned     book_counts [ENTRIES];
    bit [MOVE_W-1:0] book_moves [ENTRIES][MOVES_PER_ENTRY];
    int unsigned     entries_used;
    book_result_t    answers_due [$];
    int unsigned     mismatches;

    function void note_request(bit kind, bit [KEY_W-1:0] key, bit side,
                               bit [MOVE_W-1:0] mv, bit [PICK_W-1:0] pick);
      book_result_t answer;
      bit           found;
      answer = '0;
      found  = 1'b0;
      if (kind == KIND_INSERT) begin
        for (int unsigned i = 0; i < entries_used && !found; i++) begin
          if (book_keys[i] == key && book_sides[i] == side &&
              book_counts[i] < MOVES_PER_ENTRY) begin
            book_moves[i][book_counts[i]] = mv;
            book_counts[i]++;
            found = 1'b1;
          end
        end
        if (!found) begin
          if (entries_used < ENTRIES) begin
            book_keys[entries_used]     = key;
            book_sides[entries_used]    = side;
            book_counts[entries_used]   = 1;
            book_moves[entries_used][0] = mv;
            entries_used++;
          end else begin
            answer.full = 1'b1;
          end
        end
      end else begin
        for (int unsigned i = 0; i < entries_used && !found; i++) begin
          if (book_keys[i] == key && book_sides[i] == side) begin
            answer.hit   = 1'b1;
            answer.count = CNT_W'(book_counts[i]);
            answer.move  = book_moves[i][pick % book_counts[i]];
            found = 1'b1;
          end
        end
      end
      answers_due = {answers_due, answer};
    endfunction

    function void check_result(book_result_t got);
      book_result_t want;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%0d count=%0d move=%h full=%0d",
                   got.hit, got.count, got.move, got.full);
        return;
      end
      want = answers_due.pop_front();
      if (got.hit !== want.hit || got.count !== want.count ||
          got.move !== want.move || got.full !== want.full) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected hit=%0d count=%0d move=%h full=%0d,",
                    " got hit=%0d count=%0d move=%h full=%0d"},
                   want.hit, want.count, want.move, want.full,
                   got.hit, got.count, got.move, got.full);
      end
    endfunction
  endclass

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start          = 1'b0;
  logic              kind           = KIND_INSERT;
  logic [KEY_W-1:0]  position_key   = '0;
  logic              side_to_move   = 1'b0;
  logic [MOVE_W-1:0] move_word      = '0;
  logic [PICK_W-1:0] pick           = '0;
  logic              busy;
  logic              done_o;
  logic              hit_o;
  logic [CNT_W-1:0]  move_count_o;
  logic [MOVE_W-1:0] chosen_move_o;
  logic              table_full_o;

  book_scoreboard    sb;
  bit                steady = 1'b0;
  int unsigned       cycles = 0;
  bit [KEY_W-1:0]    pool_keys [POOL];
  bit                pool_sides [POOL];

  keyed_move_book_table uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind),
    .position_key_i (position_key),
    .side_to_move_i (side_to_move),
    .move_word_i    (move_word),
    .pick_i         (pick),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .move_count_o   (move_count_o),
    .chosen_move_o  (chosen_move_o),
    .table_full_o   (table_full_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      sb.check_result(book_result_t'{hit_o, move_count_o, chosen_move_o, table_full_o});
  end

  task automatic send_request(input bit kind_v, input bit [KEY_W-1:0] key_v,
                              input bit side_v, input bit [MOVE_W-1:0] move_v,
                              input bit [PICK_W-1:0] pick_v);
    start        <= 1'b1;
    kind         <= kind_v;
    position_key <= key_v;
    side_to_move <= side_v;
    move_word    <= move_v;
    pick         <= pick_v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(kind_v, key_v, side_v, move_v, pick_v);
    if (!steady && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12))
        @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.answers_due.size() != 0);
  endtask

  task automatic random_request();
    int unsigned       j;
    bit [KEY_W-1:0]    key_v;
    bit                side_v;
    bit                kind_v;
    bit [PICK_W-1:0]   pick_v;
    kind_v = 1'($urandom_range(0, 1));
    j = $urandom_range(0, POOL - 1);
    if ($urandom_range(0, 19) == 0) begin
      pool_keys[j]  = {$urandom, $urandom};
      pool_sides[j] = 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 99) < 85) begin
      key_v  = pool_keys[j];
      side_v = pool_sides[j] ^ ($urandom_range(0, 9) == 0);
    end else begin
      key_v  = {$urandom, $urandom};
      side_v = 1'($urandom_range(0, 1));
    end
    pick_v = ($urandom_range(0, 9) < 7) ? PICK_W'($urandom)
                                        : PICK_W'($urandom_range(0, 15));
    send_request(kind_v, key_v, side_v, $urandom, pick_v);
  endtask

  initial begin
    bit [KEY_W-1:0] busy_key;
    sb = new;
    for (int i = 0; i < POOL; i++) begin
      pool_keys[i]  = {$urandom, $urandom};
      pool_sides[i] = 1'($urandom_range(0, 1));
    end
    busy_key = {$urandom, $urandom};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty book, extremes of key, move and pick
    send_request(KIND_LOOKUP, '1, 1'b1, $urandom, '1);
    send_request(KIND_INSERT, '0, 1'b0, '0, '0);
    send_request(KIND_INSERT, '1, 1'b1, '1, '1);
    send_request(KIND_LOOKUP, '0, 1'b1, '1, '0);
    send_request(KIND_LOOKUP, '0, 1'b0, '0, '0);
    send_request(KIND_LOOKUP, '1, 1'b1, '0, '1);
    // one entry filled, the ninth move opens a second entry
    for (int n = 0; n < 9; n++)
      send_request(KIND_INSERT, busy_key, 1'b0, $urandom, PICK_W'($urandom));
    send_request(KIND_LOOKUP, busy_key, 1'b0, '0, '1);
    send_request(KIND_LOOKUP, busy_key, 1'b0, '0, PICK_W'(5));
    send_request(KIND_LOOKUP, busy_key, 1'b1, '0, '0);
    send_request(KIND_INSERT, '1, 1'b0, $urandom, PICK_W'($urandom));
    send_request(KIND_LOOKUP, '1, 1'b0, $urandom, PICK_W'(3));
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 200 && n < 320);
      random_request();
      if ($urandom_range(0, 99) == 0)
        drain();
    end
    steady = 1'b0;

    drain();
    repeat (1100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.answers_due.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
